### rtl/c8u16_pkg.sv
// Package: shared types, status codes and minimum-value table for the decoder.
package c8u16_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_OVERLONG = 3'd4
  } status_t;

  localparam int unsigned ACC_W = 31;
  localparam int unsigned CNT_W = 3;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] pending;
    logic [CNT_W-1:0] seq_len;
    logic             discarding;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
    logic        final_res;
  } result_t;

  function automatic logic [31:0] min_value(input logic [CNT_W-1:0] len);
    logic [31:0] v;
    case (len)
      3'd2:    v = 32'h0000_0080;
      3'd3:    v = 32'h0000_0800;
      3'd4:    v = 32'h0001_0000;
      3'd5:    v = 32'h0020_0000;
      3'd6:    v = 32'h0400_0000;
      3'd7:    v = 32'h8000_0000;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

### rtl/c8u16_if.sv
// Interfaces: byte input channel and code unit result channel.
interface c8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface c8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic        final_res;

  modport source (output valid, output code_unit, output status, output final_res,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input final_res,
                  output ready);
endinterface

### rtl/c8u16_decode.sv
// Sequence decoder: state registers and per-byte decode logic.
module c8u16_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              res_vld,
  output c8u16_pkg::result_t res
);
  import c8u16_pkg::*;

  dec_state_t       st_r;
  dec_state_t       st_nxt;
  logic             fail_en;
  status_t          fail_code;
  logic [ACC_W-1:0] acc_cont;
  logic [CNT_W-1:0] pend_dec;
  logic [CNT_W-1:0] lead_len;
  logic [ACC_W-1:0] lead_acc;
  logic             lead_bad;

  assign acc_cont = {st_r.acc[ACC_W-7:0], data_byte[5:0]};
  assign pend_dec = st_r.pending - CNT_W'(1);

  always_comb begin
    lead_bad = 1'b0;
    lead_len = 3'd2;
    lead_acc = ACC_W'(data_byte[4:0]);
    if (!data_byte[5]) begin
      lead_len = 3'd2;
      lead_acc = ACC_W'(data_byte[4:0]);
    end else if (!data_byte[4]) begin
      lead_len = 3'd3;
      lead_acc = ACC_W'(data_byte[3:0]);
    end else if (!data_byte[3]) begin
      lead_len = 3'd4;
      lead_acc = ACC_W'(data_byte[2:0]);
    end else if (!data_byte[2]) begin
      lead_len = 3'd5;
      lead_acc = ACC_W'(data_byte[1:0]);
    end else if (!data_byte[1]) begin
      lead_len = 3'd6;
      lead_acc = ACC_W'(data_byte[0]);
    end else begin
      lead_bad = 1'b1;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    res_vld       = 1'b0;
    res.code_unit = '0;
    res.status    = ST_OK;
    res.final_res = last_byte;
    fail_en       = 1'b0;
    fail_code     = ST_OK;
    if (st_r.discarding) begin
      if (last_byte) begin
        st_nxt.discarding = 1'b0;
      end
    end else if (st_r.pending == '0) begin
      if (!data_byte[7]) begin
        res_vld       = 1'b1;
        res.code_unit = {8'h00, data_byte};
      end else if (!data_byte[6] || lead_bad) begin
        fail_en   = 1'b1;
        fail_code = ST_BAD_LEAD;
      end else if (last_byte) begin
        fail_en   = 1'b1;
        fail_code = ST_TRUNC;
      end else begin
        st_nxt.acc     = lead_acc;
        st_nxt.seq_len = lead_len;
        st_nxt.pending = lead_len - CNT_W'(1);
      end
    end else if (data_byte[7:6] != 2'b10) begin
      fail_en   = 1'b1;
      fail_code = ST_BAD_CONT;
    end else if (pend_dec != '0) begin
      if (last_byte) begin
        fail_en   = 1'b1;
        fail_code = ST_TRUNC;
      end else begin
        st_nxt.acc     = acc_cont;
        st_nxt.pending = pend_dec;
      end
    end else if ({1'b0, acc_cont} < min_value(st_r.seq_len)) begin
      fail_en   = 1'b1;
      fail_code = ST_OVERLONG;
    end else begin
      st_nxt.acc     = '0;
      st_nxt.pending = '0;
      st_nxt.seq_len = '0;
      res_vld        = 1'b1;
      res.code_unit  = acc_cont[15:0];
    end

    if (fail_en) begin
      st_nxt            = '0;
      st_nxt.discarding = !last_byte;
      res_vld           = 1'b1;
      res.code_unit     = '0;
      res.status        = fail_code;
      res.final_res     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

### rtl/c8u16_out_buf.sv
// Result buffer: output register with one skid entry.
module c8u16_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  c8u16_pkg::result_t push_res,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output c8u16_pkg::result_t out_res
);
  import c8u16_pkg::*;

  logic    main_vld_r;
  logic    skid_vld_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop       = main_vld_r && out_ready;
  assign space_ok  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (main_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        main_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_vld_r && !pop) begin
        skid_r <= push_res;
      end else begin
        main_r <= push_res;
      end
    end
  end

endmodule

### rtl/cesu8_to_utf16_decoder.sv
// Top level: byte-stream decoder to 16-bit code units with error status.
//
// in_ch carries one byte per transfer with last_byte marking a string's end.
// out_ch carries code_unit, status and final_res; at most one result per byte.
// Bytes inside a multi-byte sequence and bytes dropped after an error
// produce no result.
// One byte is taken every cycle while in_ch.ready is high; the decode is a single pass of logic
// between the sequence state registers and the result register.
// A result is registered when the byte that completes its sequence (or exposes
// its error) is transferred.
// When out_ch stalls, one further result is held in a skid entry; in_ch.ready
// then drops until the skid entry drains. Bytes that give no result are
// still gated by in_ch.ready while the skid entry is full.
// Synchronous active-low reset clears the decode state and empties the
// result buffer; the first byte after reset starts a new string.
module cesu8_to_utf16_decoder (
  input  logic           clk,
  input  logic           rst_n,
  c8u16_in_if.sink       in_ch,
  c8u16_out_if.source    out_ch
);
  import c8u16_pkg::*;

  logic    accept;
  logic    res_vld;
  result_t res;
  result_t out_res;

  assign accept = in_ch.valid && in_ch.ready;

  c8u16_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .res_vld   (res_vld),
    .res       (res)
  );

  c8u16_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_vld),
    .push_res  (res),
    .space_ok  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.code_unit = out_res.code_unit;
  assign out_ch.status    = out_res.status;
  assign out_ch.final_res = out_res.final_res;

endmodule
